FILE: rtl/ridc_pkg.sv
// Shared types and constants for the request identifier duplicate filter.
`timescale 1ns / 1ps
`default_nettype none

package ridc_pkg;

  // Byte value that terminates an identifier.
  localparam logic [7:0] ID_END = 8'h00;

  // Item kinds carried on the input tuser bit.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Per-cycle strobes broadcast from the top level to every cell.
  typedef struct packed {
    logic clear;   // Empty the whole store and send the head home.
    logic cmp;     // A nonzero identifier byte is being compared.
    logic term;    // The terminating byte is being compared.
    logic commit;  // The finished identifier missed and is written at the head.
  } cam_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/request_id_dedup_ring_cam_top.sv
// Top level of the request identifier duplicate filter built as a ring of compare cells.
//
// Input channel: one item per identifier byte (in_tdata) or a clear command
// (in_tuser set). A zero byte ends the identifier. Each byte is compared against
// every entry by a row of ENTRIES cells; a cell keeps a sticky mismatch bit for
// the identifier in progress.
// Output channel: exactly one item per terminating byte, hit in bit 0 of
// out_tdata: 1 if a filled entry equals the identifier, 0 if it was stored.
// On a miss the identifier (cut to MAX_ID_LEN characters) is written into the
// cell that holds the ring token, and the token moves to the next cell, so the
// oldest entry is overwritten first. A clear empties all cells.
// Throughput: one item per cycle while no terminating byte waits for out_tready;
// the registered result appears in the cycle after its terminating byte is accepted.
// While an unread result waits in the output register, nonzero bytes and
// clears are still taken; only the next terminating byte waits for out_tready.
// Reset empties the store, sends the ring token to entry 0 and drops any
// pending result. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module request_id_dedup_ring_cam_top #(
  parameter int ENTRIES    = 16,
  parameter int MAX_ID_LEN = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] id_byte
  input  wire  [0:0] in_tuser,   // [0] action
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // [0] hit, [7:1] zero
);

  localparam int PW = $clog2(MAX_ID_LEN + 1);
  localparam int IW = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;
  localparam int SW = MAX_ID_LEN * 8;

  ridc_pkg::cam_ctl_t ctl;
  logic               acc;
  logic               is_clr;
  logic               is_end;
  logic               hit;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] tok;
  logic [ENTRIES-1:0] filled;
  logic [SW-1:0]      stage;
  logic [7:0]         stg_r [MAX_ID_LEN];
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic               out_hit_r;

  assign is_clr = (in_tuser[0] == ridc_pkg::KIND_CLEAR);
  assign is_end = (in_tdata == ridc_pkg::ID_END);

  // A terminating byte needs a free output register; other items always go in.
  assign in_tready = ~out_tvalid_r | out_tready | is_clr | ~is_end;
  assign acc       = in_tvalid & in_tready;
  assign hit       = |match;

  // Strobes shared by all cells.
  always_comb begin
    ctl.clear  = acc & is_clr;
    ctl.cmp    = acc & ~is_clr & ~is_end;
    ctl.term   = acc & ~is_clr & is_end;
    ctl.commit = acc & ~is_clr & is_end & ~hit;
  end

  // Byte position of the identifier in progress, saturating at the maximum length.
  always_comb begin
    pos_nxt = pos_r;
    if (ctl.clear || ctl.term) begin
      pos_nxt = '0;
    end else if (ctl.cmp && (pos_r < PW'(MAX_ID_LEN))) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Staging buffer for the characters of the identifier in progress.
  always_ff @(posedge clk) begin
    if (ctl.cmp && (pos_r < PW'(MAX_ID_LEN))) begin
      stg_r[pos_r[IW-1:0]] <= in_tdata;
    end
  end

  for (genvar k = 0; k < MAX_ID_LEN; k++) begin : g_stage
    assign stage[k*8 +: 8] = stg_r[k];
  end

  // Row of entry cells; the ring token passes from each cell to the next.
  for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
    localparam int PREV = (e == 0) ? ENTRIES - 1 : e - 1;
    ridc_cell #(
      .MAX_ID_LEN (MAX_ID_LEN),
      .PW         (PW),
      .IW         (IW),
      .HOME       (e == 0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .ch      (in_tdata),
      .pos     (pos_r),
      .stage   (stage),
      .tok_in  (tok[PREV]),
      .tok_out (tok[e]),
      .filled  (filled[e]),
      .match   (match[e])
    );
  end

  // Output register holding one result item.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (ctl.term) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.term) begin
      out_hit_r <= hit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_hit_r};

`ifndef ASSERT_OFF
  // Exactly one cell holds the ring head.
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(tok))
    else $error("ring token is not one-hot");

  // A clear leaves every entry empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (filled == '0))
    else $error("entries still filled after clear");

  // A hit writes nothing, so the head stays where it was.
  a_hit_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.term && hit) |=> $stable(tok) && $stable(filled))
    else $error("ring head moved on a hit");

  // A new result appears only after a terminating byte was taken.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(ctl.term))
    else $error("result without a terminating byte");

  // Before the ring is full the head is never on a filled entry, as entries fill in
  // ring order: an empty entry following a filled one is always the head.
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (filled != '0 && filled != '1) |-> ((filled & tok) == '0))
    else $error("head points at a filled entry before the ring is full");
`endif

endmodule

`default_nettype wire

FILE: rtl/ridc_cell.sv
// One entry of the duplicate filter: stored identifier, compare logic and ring token.
`timescale 1ns / 1ps
`default_nettype none

module ridc_cell #(
  parameter int  MAX_ID_LEN = 32,
  parameter int  PW         = 6,
  parameter int  IW         = 5,
  parameter bit  HOME       = 1'b0
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  ridc_pkg::cam_ctl_t   ctl,
  input  wire  [7:0]                 ch,
  input  wire  [PW-1:0]              pos,
  input  wire  [MAX_ID_LEN*8-1:0]    stage,
  input  wire                        tok_in,
  output logic                       tok_out,
  output logic                       filled,
  output logic                       match
);

  logic [7:0]    data_r [MAX_ID_LEN];
  logic [PW-1:0] len_r, len_nxt;
  logic          filled_r, filled_nxt;
  logic          mism_r, mism_nxt;
  logic          tok_r, tok_nxt;
  logic [7:0]    stored;
  logic          wr_en;

  // Byte of this entry at the current position; past the stored length it reads as zero.
  always_comb begin
    if (pos < len_r) begin
      stored = data_r[pos[IW-1:0]];
    end else begin
      stored = ridc_pkg::ID_END;
    end
  end

  // The entry matches when it is filled and has never differed, including at the end.
  assign match   = filled_r & ~(mism_r | (stored != ridc_pkg::ID_END));
  assign wr_en   = ctl.commit & tok_r;
  assign tok_out = tok_r;
  assign filled  = filled_r;

  // Next values of the control state.
  always_comb begin
    len_nxt    = len_r;
    filled_nxt = filled_r;
    mism_nxt   = mism_r;
    tok_nxt    = tok_r;
    if (ctl.clear) begin
      len_nxt    = '0;
      filled_nxt = 1'b0;
      mism_nxt   = 1'b0;
      tok_nxt    = HOME;
    end else if (ctl.cmp) begin
      mism_nxt = mism_r | (stored != ch);
    end else if (ctl.term) begin
      mism_nxt = 1'b0;
      if (ctl.commit) begin
        tok_nxt = tok_in;
        if (tok_r) begin
          len_nxt    = pos;
          filled_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      filled_r <= 1'b0;
      mism_r   <= 1'b0;
      tok_r    <= HOME;
    end else begin
      len_r    <= len_nxt;
      filled_r <= filled_nxt;
      mism_r   <= mism_nxt;
      tok_r    <= tok_nxt;
    end
  end

  // Identifier bytes are loaded from the staging buffer on a miss when this cell holds the head.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < MAX_ID_LEN; k++) begin
        data_r[k] <= stage[k*8 +: 8];
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/request_id_dedup_ring_cam_top_tb.sv
// Self-checking testbench for the request identifier duplicate filter.
`timescale 1ns / 1ps

module request_id_dedup_ring_cam_top_tb;

  localparam int ENTRIES    = 16;
  localparam int MAX_ID_LEN = 32;
  localparam int POOL_IDS   = 24;
  localparam int POOL_CHARS = 48;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;

  // Item kinds and the terminating byte, taken from the shared package.
  localparam logic       KIND_BYTE  = ridc_pkg::KIND_BYTE;
  localparam logic       KIND_CLEAR = ridc_pkg::KIND_CLEAR;
  localparam logic [7:0] ID_END     = ridc_pkg::ID_END;

  typedef struct packed {
    logic       act;
    logic [7:0] ch;
  } req_item_t;

  // Receiver behaviors that rotate during the run.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_LONG_STALL,
    RX_EVERY_THIRD
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] id_byte
  logic [0:0] in_tuser = 1'b0;    // [0] action
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] hit, [7:1] zero

  request_id_dedup_ring_cam_top #(
    .ENTRIES   (ENTRIES),
    .MAX_ID_LEN(MAX_ID_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Items waiting to be driven and hit flags waiting to be seen.
  req_item_t pending_items[$];
  logic      expected_hits[$];
  int        mismatch_count = 0;
  int        items_queued = 0;
  logic      in_fire = 1'b0;

  // Shadow copy of the cache used to predict each hit flag.
  logic [7:0]         shadow_store [ENTRIES][MAX_ID_LEN+1];
  logic [7:0]         shadow_stage [MAX_ID_LEN+1];
  logic [ENTRIES-1:0] shadow_differs;
  int unsigned        shadow_pos;
  int unsigned        shadow_head;
  int unsigned        shadow_fill;

  // Identifier pool reused so that duplicates and ring replacement happen.
  logic [7:0] pool_chars [POOL_IDS][POOL_CHARS];
  int         pool_len [POOL_IDS];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void begin_new_id();
    for (int i = 0; i <= MAX_ID_LEN; i++) shadow_stage[i] = 8'h00;
    shadow_differs = '0;
    shadow_pos = 0;
  endfunction

  // Update the shadow cache for one accepted item; a terminator queues its hit flag.
  task automatic dedup_lookup(input logic act, input logic [7:0] ch);
    int unsigned p;
    logic        hit;
    if (act == KIND_CLEAR) begin
      for (int e = 0; e < ENTRIES; e++)
        for (int i = 0; i <= MAX_ID_LEN; i++) shadow_store[e][i] = 8'h00;
      shadow_head = 0;
      shadow_fill = 0;
      begin_new_id();
      return;
    end
    p = (shadow_pos > MAX_ID_LEN) ? MAX_ID_LEN : shadow_pos;
    if (ch != ID_END) begin
      // An overlong identifier differs from every entry.
      for (int e = 0; e < ENTRIES; e++)
        if (p >= MAX_ID_LEN || shadow_store[e][p] != ch) shadow_differs[e] = 1'b1;
      if (p < MAX_ID_LEN) begin
        shadow_stage[p] = ch;
        shadow_pos = p + 1;
      end else begin
        shadow_pos = MAX_ID_LEN;
      end
      return;
    end
    // At the terminator the stored entry must end at the same position.
    hit = 1'b0;
    for (int e = 0; e < ENTRIES; e++) begin
      if (shadow_store[e][p] != 8'h00) shadow_differs[e] = 1'b1;
      if (e < shadow_fill && !shadow_differs[e]) hit = 1'b1;
    end
    if (!hit) begin
      for (int i = 0; i <= MAX_ID_LEN; i++)
        shadow_store[shadow_head][i] = (i < p) ? shadow_stage[i] : 8'h00;
      shadow_head = (shadow_head + 1) % ENTRIES;
      if (shadow_fill < ENTRIES) shadow_fill++;
    end
    expected_hits.push_back(hit);
    begin_new_id();
  endtask

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic push_item(input logic act, input logic [7:0] ch);
    req_item_t it;
    it.act = act;
    it.ch  = ch;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_random_id(input int len);
    for (int i = 0; i < len; i++) push_item(KIND_BYTE, 8'($urandom_range(1, 255)));
    push_item(KIND_BYTE, ID_END);
  endtask

  // Send a pool identifier, optionally with one character altered.
  task automatic push_pool_id(input int k, input bit mutate);
    int         pos;
    logic [7:0] ch;
    pos = (pool_len[k] > 0) ? $urandom_range(0, pool_len[k] - 1) : 0;
    for (int i = 0; i < pool_len[k]; i++) begin
      ch = pool_chars[k][i];
      if (mutate && i == pos) ch = 8'($urandom_range(1, 255));
      push_item(KIND_BYTE, ch);
    end
    push_item(KIND_BYTE, ID_END);
  endtask

  task automatic fill_pool_slot(input int k, input int len);
    pool_len[k] = len;
    for (int i = 0; i < POOL_CHARS; i++) pool_chars[k][i] = 8'($urandom_range(1, 255));
  endtask

  task automatic build_stimulus();
    int sel;
    // Directed part: empty identifier, repeats, prefixes, clears mid-identifier.
    push_item(KIND_BYTE, ID_END);
    push_item(KIND_BYTE, ID_END);
    push_item(KIND_BYTE, 8'hFF); push_item(KIND_BYTE, 8'h01); push_item(KIND_BYTE, ID_END);
    push_item(KIND_BYTE, 8'hFF); push_item(KIND_BYTE, 8'h01); push_item(KIND_BYTE, ID_END);
    push_item(KIND_BYTE, 8'hFF); push_item(KIND_BYTE, ID_END);
    push_item(KIND_BYTE, 8'hFF); push_item(KIND_BYTE, 8'h01); push_item(KIND_BYTE, 8'h02);
    push_item(KIND_BYTE, ID_END);
    push_item(KIND_BYTE, 8'h80); push_item(KIND_CLEAR, 8'h55);
    push_item(KIND_BYTE, 8'hFF); push_item(KIND_BYTE, 8'h01); push_item(KIND_BYTE, ID_END);
    push_item(KIND_CLEAR, 8'h00);
    push_item(KIND_BYTE, ID_END);

    // Pool: a full-length identifier, longer ones sharing its prefix, a shorter
    // prefix, the empty identifier, a single character, and random short ones.
    fill_pool_slot(0, MAX_ID_LEN);
    fill_pool_slot(1, MAX_ID_LEN + 1);
    fill_pool_slot(2, MAX_ID_LEN + 8);
    for (int i = 0; i < MAX_ID_LEN; i++) begin
      pool_chars[1][i] = pool_chars[0][i];
      pool_chars[2][i] = pool_chars[0][i];
    end
    fill_pool_slot(3, MAX_ID_LEN - 1);
    for (int i = 0; i < MAX_ID_LEN - 1; i++) pool_chars[3][i] = pool_chars[0][i];
    fill_pool_slot(4, 0);
    fill_pool_slot(5, 1);
    for (int k = 6; k < POOL_IDS; k++) fill_pool_slot(k, $urandom_range(1, 12));

    // Random part: mostly well-formed pool traffic, plus noise and broken sequences.
    while (items_queued < RANDOM_ITEMS + 21) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        push_pool_id($urandom_range(0, POOL_IDS - 1), $urandom_range(0, 9) == 0);
      end else if (sel < 85) begin
        push_random_id($urandom_range(0, 10));
      end else if (sel < 90) begin
        push_random_id($urandom_range(MAX_ID_LEN + 1, MAX_ID_LEN + 13));
      end else if (sel < 97) begin
        // Identifier abandoned by a clear.
        for (int i = $urandom_range(1, 10); i > 0; i--)
          push_item(KIND_BYTE, 8'($urandom_range(1, 255)));
        push_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        push_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 19) == 0)
        fill_pool_slot($urandom_range(6, POOL_IDS - 1), $urandom_range(1, 12));
    end
  endtask

  // Monitor: predict on each accepted input item, check each accepted result.
  always @(posedge clk) begin : monitor_proc
    logic exp_hit;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) dedup_lookup(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          note_error($sformatf("result 0x%02h with no identifier pending", out_tdata));
        end else begin
          exp_hit = expected_hits.pop_front();
          if (out_tdata !== {7'b0, exp_hit})
            note_error($sformatf("hit expected 0x%02h got 0x%02h",
                                 {7'b0, exp_hit}, out_tdata));
        end
      end
    end
  end

  // Driver: bursts of items separated by random gaps, valid held until taken.
  always @(negedge clk) begin : driver_proc
    logic nxt_valid;
    int   burst_left;
    int   gap_left;
    if (rst_n) begin
      if (in_fire) pending_items.delete(0);
      if (in_tvalid && !in_fire) begin
        nxt_valid = 1'b1;
      end else if (pending_items.size() == 0) begin
        nxt_valid = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        nxt_valid = 1'b0;
      end else begin
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 20);
            default: gap_left = $urandom_range(1, 4);
          endcase
        end
      end
      in_tvalid <= nxt_valid;
      if (nxt_valid) begin
        in_tdata    <= pending_items[0].ch;
        in_tuser[0] <= pending_items[0].act;
      end
    end
  end

  // Receiver: the ready pattern switches now and then to a randomly chosen behavior.
  always @(negedge clk) begin : receiver_proc
    rx_mode_t rx_mode;
    int       phase_cnt;
    int       stall_left;
    if (!rst_n) begin
      rx_mode    = RX_OPEN;
      phase_cnt  = 0;
      stall_left = 0;
    end else begin
      phase_cnt++;
      if (phase_cnt == 300) begin
        phase_cnt = 0;
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom_range(0, 1));
        RX_LONG_STALL: begin
          if (stall_left > 0) begin
            stall_left--;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 25);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
        default: out_tready <= (phase_cnt % 3 == 0);
      endcase
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin : watchdog_proc
    int cycles;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main sequence: stimulus, reset, drain, verdict.
  initial begin
    dedup_lookup(KIND_CLEAR, 8'h00);
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
